// ===== hdl/bmp_pkg.sv =====
// Shared types and constants for the binomial / modular power engine.
// No dependencies.
`default_nettype none
package bmp_pkg;

	localparam logic [29:0] MODP       = 30'd1000000007;
	localparam logic [31:0] MODP_X2    = 32'd2000000014;
	localparam logic [63:0] FERMAT_EXP = 64'd1000000005;
	localparam int          MUL_STEPS  = 30;

	localparam logic [1:0] CMD_BUILD = 2'd0;
	localparam logic [1:0] CMD_NCR   = 2'd1;
	localparam logic [1:0] CMD_POW   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BLD_NEXT,
		ST_BLD_FACT,
		ST_POW_CHECK,
		ST_POW_MUL,
		ST_POW_SQR,
		ST_NCR_A,
		ST_NCR_B,
		ST_NCR_C,
		ST_NCR_M1,
		ST_NCR_M2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        start;
		logic [29:0] a;
		logic [29:0] b;
	} mm_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [29:0] prod;
	} mm_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/bmp_mulmod.sv =====
// Bit-serial modular multiplier: a*b mod MODP, one bit of a per cycle, MSB first.
// Depends on bmp_pkg. Operands must be below MODP.
`default_nettype none
module bmp_mulmod (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bmp_pkg::mm_req_t  req,
	output bmp_pkg::mm_rsp_t       rsp
);
	import bmp_pkg::*;

	localparam int CW = $clog2(MUL_STEPS);
	localparam logic [CW-1:0] LAST = CW'(MUL_STEPS - 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [29:0]   a_q;
	logic [29:0]   b_q;
	logic [29:0]   acc_q;
	logic [31:0]   sum;
	logic [29:0]   red;

	// acc < p and b < p, so 2*acc + b < 3p: one subtraction of p or 2p suffices
	always_comb begin
		sum = {1'b0, acc_q, 1'b0} + (a_q[29] ? {2'b00, b_q} : 32'd0);
		if (sum >= MODP_X2)
			red = 30'(sum - MODP_X2);
		else if (sum >= {2'b00, MODP})
			red = 30'(sum - {2'b00, MODP});
		else
			red = sum[29:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q   <= {a_q[28:0], 1'b0};
			acc_q <= red;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule
`default_nettype wire

// ===== hdl/binomial_mod_prime_engine.sv =====
// Top level: command sequencer, factorial tables and result register.
// Depends on bmp_pkg and bmp_mulmod.
//
// Modular engine over p = 1000000007 built around one bit-serial multiplier. A power
// query squares once for each exponent bit up to the highest set bit and multiplies
// once more for each set bit. Trivial binomial cases (r > n, r = 0, r = n, out of
// range) skip the tables. A build works out each inverse factorial as a 30-bit
// Fermat exponentiation on the same multiplier. One item is worked at a time; the
// next item may be taken while the previous result waits.
// Table entries are read only after a build has written them.
`default_nettype none
module binomial_mod_prime_engine #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [9:0]  n_value,
	input  wire logic [9:0]  r_value,
	input  wire logic [29:0] base,
	input  wire logic [63:0] exponent,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [29:0]      value,
	output logic             status
);
	import bmp_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	state_t state_q, state_d;

	logic [29:0] fact_mem [TABLE_DEPTH];
	logic [29:0] inv_mem  [TABLE_DEPTH];

	logic        mode_bld_q;
	logic [9:0]  lim_q;
	logic [10:0] i_q;
	logic [29:0] f_q;
	logic [29:0] pb_q;
	logic [63:0] pe_q;
	logic [29:0] acc_q;
	logic [9:0]  n_q;
	logic [9:0]  r_q;
	logic [29:0] x_q;
	logic [29:0] fact_rd_q;
	logic [29:0] inv_rd_q;
	logic [29:0] res_q;
	logic        stat_q;
	logic [29:0] value_q;
	logic        status_q;
	logic        out_valid_q;
	logic [9:0]  built_limit_q;
	logic        tables_valid_q;

	mm_req_t mm_req;
	mm_rsp_t mm_rsp;

	logic        accept;
	logic        slot_free;
	logic        out_load;
	logic [9:0]  in_lim;
	logic [9:0]  n_minus_r;
	logic        fact_we;
	logic [29:0] fact_wd;
	logic [AW-1:0] fact_wa;
	logic        inv_we;
	logic [29:0] inv_wd;
	logic [AW-1:0] inv_wa;
	logic        fact_re;
	logic        inv_re;
	logic [AW-1:0] inv_ra;
	logic        bld_end;
	logic        pow_end;

	bmp_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign in_lim    = (32'(n_value) >= TABLE_DEPTH) ? 10'(TABLE_DEPTH - 1) : n_value;
	assign n_minus_r = n_q - r_q;
	assign bld_end   = (state_q == ST_BLD_NEXT) && (i_q > {1'b0, lim_q});
	assign pow_end   = (state_q == ST_POW_CHECK) && (pe_q == 64'd0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_BUILD: state_d = ST_BLD_NEXT;
						CMD_NCR: begin
							if (r_value > n_value || r_value == 10'd0 || r_value == n_value
									|| !tables_valid_q || n_value > built_limit_q)
								state_d = ST_DONE;
							else
								state_d = ST_NCR_A;
						end
						CMD_POW: state_d = exponent[63] ? ST_DONE : ST_POW_CHECK;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_BLD_NEXT:  state_d = bld_end ? ST_DONE : ST_BLD_FACT;
			ST_BLD_FACT:  if (mm_rsp.done) state_d = ST_POW_CHECK;
			ST_POW_CHECK: begin
				if (pe_q == 64'd0)
					state_d = mode_bld_q ? ST_BLD_NEXT : ST_DONE;
				else
					state_d = pe_q[0] ? ST_POW_MUL : ST_POW_SQR;
			end
			ST_POW_MUL:   if (mm_rsp.done) state_d = ST_POW_SQR;
			ST_POW_SQR:   if (mm_rsp.done) state_d = ST_POW_CHECK;
			ST_NCR_A:     state_d = ST_NCR_B;
			ST_NCR_B:     state_d = ST_NCR_C;
			ST_NCR_C:     state_d = ST_NCR_M1;
			ST_NCR_M1:    if (mm_rsp.done) state_d = ST_NCR_M2;
			ST_NCR_M2:    if (mm_rsp.done) state_d = ST_DONE;
			ST_DONE:      if (slot_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		out_load     = (state_q == ST_DONE) && slot_free;
		mm_req.start = 1'b0;
		mm_req.a     = pb_q;
		mm_req.b     = pb_q;
		fact_we      = 1'b0;
		fact_wa      = '0;
		fact_wd      = 30'd1;
		inv_we       = 1'b0;
		inv_wa       = '0;
		inv_wd       = 30'd1;
		fact_re      = 1'b0;
		inv_re       = 1'b0;
		inv_ra       = AW'(n_minus_r);
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_BUILD) begin
					fact_we = 1'b1;
					inv_we  = 1'b1;
				end
			end
			ST_BLD_NEXT: begin
				if (!bld_end) begin
					mm_req.start = 1'b1;
					mm_req.a     = f_q;
					mm_req.b     = 30'(i_q);
				end
			end
			ST_BLD_FACT: begin
				fact_we = mm_rsp.done;
				fact_wa = AW'(i_q);
				fact_wd = mm_rsp.prod;
			end
			ST_POW_CHECK: begin
				if (pe_q != 64'd0) begin
					mm_req.start = 1'b1;
					mm_req.a     = pe_q[0] ? acc_q : pb_q;
				end else if (mode_bld_q) begin
					inv_we = 1'b1;
					inv_wa = AW'(i_q);
					inv_wd = acc_q;
				end
			end
			ST_POW_MUL: mm_req.start = mm_rsp.done;
			ST_NCR_A: begin
				fact_re = 1'b1;
				inv_re  = 1'b1;
				inv_ra  = AW'(r_q);
			end
			ST_NCR_B: inv_re = 1'b1;
			ST_NCR_C: begin
				mm_req.start = 1'b1;
				mm_req.a     = x_q;
				mm_req.b     = inv_rd_q;
			end
			ST_NCR_M1: begin
				mm_req.start = mm_rsp.done;
				mm_req.a     = fact_rd_q;
				mm_req.b     = mm_rsp.prod;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fact_we)
			fact_mem[fact_wa] <= fact_wd;
		if (inv_we)
			inv_mem[inv_wa] <= inv_wd;
		if (fact_re)
			fact_rd_q <= fact_mem[AW'(n_q)];
		if (inv_re)
			inv_rd_q <= inv_mem[inv_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			built_limit_q  <= '0;
			tables_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (bld_end) begin
				built_limit_q  <= lim_q;
				tables_valid_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q  <= res_q;
			status_q <= stat_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					// r = 0 and r = n give 1, r > n gives 0, range errors give status 1 and value 0
					res_q      <= (cmd == CMD_NCR && r_value <= n_value
						&& (r_value == 10'd0 || r_value == n_value)) ? 30'd1 : 30'd0;
					stat_q     <= (cmd == CMD_NCR) && (r_value < n_value)
						&& (r_value != 10'd0)
						&& (!tables_valid_q || n_value > built_limit_q);
					n_q        <= n_value;
					r_q        <= r_value;
					lim_q      <= in_lim;
					i_q        <= 11'd1;
					f_q        <= 30'd1;
					mode_bld_q <= (cmd == CMD_BUILD);
					acc_q      <= 30'd1;
					pb_q       <= (base >= MODP) ? base - MODP : base;
					pe_q       <= exponent;
				end
			end
			ST_BLD_NEXT: res_q <= 30'd0;
			ST_BLD_FACT: begin
				if (mm_rsp.done) begin
					f_q   <= mm_rsp.prod;
					pb_q  <= mm_rsp.prod;
					pe_q  <= FERMAT_EXP;
					acc_q <= 30'd1;
				end
			end
			ST_POW_CHECK: begin
				if (pe_q == 64'd0) begin
					if (mode_bld_q)
						i_q <= i_q + 11'd1;
					else
						res_q <= acc_q;
				end
			end
			ST_POW_MUL: if (mm_rsp.done) acc_q <= mm_rsp.prod;
			ST_POW_SQR: begin
				if (mm_rsp.done) begin
					pb_q <= mm_rsp.prod;
					pe_q <= pe_q >> 1;
				end
			end
			ST_NCR_B:  x_q <= inv_rd_q;
			ST_NCR_M2: if (mm_rsp.done) res_q <= mm_rsp.prod;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(mm_req.start && mm_rsp.busy))
		else $error("multiplier started while busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> (state_q == ST_BLD_FACT || state_q == ST_POW_MUL
			|| state_q == ST_POW_SQR || state_q == ST_NCR_M1 || state_q == ST_NCR_M2))
		else $error("product arrived outside a wait state");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (value == 30'd0))
		else $error("range error with nonzero value");

	a_tables_stay: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(tables_valid_q))
		else $error("tables lost their valid mark");

	a_pow_end_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(pow_end && !mode_bld_q) |=> (state_q == ST_DONE))
		else $error("power result did not reach the output stage");

endmodule
`default_nettype wire
